@@ rtl/core/ttmf_pkg.sv @@
// Shared constants and types for the touch trimmed-mean filter.
// No dependencies; imported by touch_trimmed_mean_filter and its checker.
`default_nettype none

package ttmf_pkg;

    localparam int SAMPLES   = 10;
    localparam int SMP_W     = 12;
    localparam int X_W       = 12;
    localparam int Y_W       = 11;
    localparam int IDX_W     = $clog2(SAMPLES);
    localparam int RANK_LO   = 3;
    localparam int RANK_HI   = 5;
    localparam int SUM_W     = 14;
    localparam int RECIP_W   = 14;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int DIV_SHIFT = 15;

    // floor(s / 3) == (s * RECIP3) >> DIV_SHIFT for s < 2**SUM_W
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(10923);
    localparam logic [Y_W-1:0]     Y_TOP  = Y_W'(2047);

    typedef struct packed {
        logic [SMP_W-1:0] y;
        logic [SMP_W-1:0] x;
    } pair_t;

    typedef enum logic [5:0] {
        ST_COLLECT = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_NEXT    = 6'b000100,
        ST_DIV     = 6'b001000,
        ST_MEAN    = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/touch_trimmed_mean_filter.sv @@
// Touch trimmed-mean filter: collects SAMPLES X/Y pairs, ranks each channel with one
// shared comparator over a rotating sample ring, averages ranks 3..5 and outputs Y as
// Y_TOP minus its mean, clamped at 0. Depends on ttmf_pkg. Non-final samples are accepted
// while in_ready is high; the set-completing sample starts the rank scan, which holds
// in_ready low until the result is emitted, also while out_ready stalls it.
// Reset: rst_n (async, active low) clears the sequencer, sample count and output valid.
`default_nettype none

module touch_trimmed_mean_filter (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [ttmf_pkg::SMP_W-1:0] x_sample,
    input  wire  [ttmf_pkg::SMP_W-1:0] y_sample,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [ttmf_pkg::X_W-1:0] x_position,
    output logic [ttmf_pkg::Y_W-1:0] y_position
);
    import ttmf_pkg::*;

    localparam logic [IDX_W-1:0] LAST    = IDX_W'(SAMPLES - 1);
    localparam logic [IDX_W:0]   N_WIDE  = (IDX_W + 1)'(SAMPLES);
    localparam logic [IDX_W-1:0] R_LO    = IDX_W'(RANK_LO);
    localparam logic [IDX_W-1:0] R_HI    = IDX_W'(RANK_HI);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic              chan_reg, chan_next;
    logic              out_valid_reg, out_valid_next;

    pair_t             ring_reg [SAMPLES];
    pair_t             cand_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg;
    logic [X_W-1:0]    x_mean_reg;
    logic [Y_W-1:0]    y_res_reg;
    logic [X_W-1:0]    x_out_reg;
    logic [Y_W-1:0]    y_out_reg;

    logic              in_xfer;
    logic              slot_free;
    logic              shift_in;
    logic              rotate;
    logic [SMP_W-1:0]  cur_val;
    logic [SMP_W-1:0]  cand_val;
    logic              tie_win;
    logic              less;
    logic [SMP_W-1:0]  mean;
    logic [Y_W-1:0]    y_calc;

    assign in_ready   = (state_reg == ST_COLLECT);
    assign in_xfer    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign x_position = x_out_reg;
    assign y_position = y_out_reg;

    // shared compare unit; ties broken by original slot order
    assign cur_val  = chan_reg ? ring_reg[0].y : ring_reg[0].x;
    assign cand_val = chan_reg ? cand_reg.y : cand_reg.x;
    assign tie_win  = (({1'b0, j_reg} + {1'b0, i_reg}) >= N_WIDE);
    assign less     = (cur_val < cand_val) || ((cur_val == cand_val) && tie_win);

    assign mean   = prod_reg[DIV_SHIFT +: SMP_W];
    assign y_calc = (mean > {1'b0, Y_TOP}) ? '0 : (Y_TOP - mean[Y_W-1:0]);

    assign shift_in = in_xfer;
    assign rotate   = (state_reg == ST_SCAN) || (state_reg == ST_NEXT);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        chan_next      = chan_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    if (count_reg == LAST)
                    begin
                        count_next = '0;
                        i_next     = '0;
                        j_next     = '0;
                        rank_next  = '0;
                        chan_next  = 1'b0;
                        sum_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                rank_next = rank_reg + IDX_W'(less);
                j_next    = j_reg + 1'b1;
                if (j_reg == LAST)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if ((rank_reg >= R_LO) && (rank_reg <= R_HI))
                begin
                    sum_next = sum_reg + SUM_W'(cand_val);
                end
                j_next    = '0;
                rank_next = '0;
                if (i_reg == LAST)
                begin
                    i_next     = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DIV:
            begin
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                sum_next = '0;
                if (chan_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    chan_next  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            chan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rank_reg      <= rank_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_in)
        begin
            for (int k = 0; k < SAMPLES - 1; k++)
            begin
                ring_reg[k] <= ring_reg[k+1];
            end
            ring_reg[SAMPLES-1] <= '{y: y_sample, x: x_sample};
        end
        else if (rotate)
        begin
            for (int k = 0; k < SAMPLES - 1; k++)
            begin
                ring_reg[k] <= ring_reg[k+1];
            end
            ring_reg[SAMPLES-1] <= ring_reg[0];
        end

        // next candidate sits one slot ahead of the ring head
        if ((in_xfer && (count_reg == LAST)) || (state_reg == ST_NEXT))
        begin
            cand_reg <= ring_reg[1];
        end

        sum_reg <= sum_next;

        if (state_reg == ST_DIV)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP3);
        end

        if ((state_reg == ST_MEAN) && !chan_reg)
        begin
            x_mean_reg <= mean;
        end
        if ((state_reg == ST_MEAN) && chan_reg)
        begin
            y_res_reg <= y_calc;
        end

        if ((state_reg == ST_EMIT) && slot_free)
        begin
            x_out_reg <= x_mean_reg;
            y_out_reg <= y_res_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ttmf_checker.sv @@
// Port-level checker for touch_trimmed_mean_filter, attached by bind.
// Depends on ttmf_pkg.
`default_nettype none

module ttmf_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [ttmf_pkg::X_W-1:0]     x_position,
    input wire [ttmf_pkg::Y_W-1:0]     y_position
);
    import ttmf_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SAMPLES - 1);

    logic [IDX_W-1:0] seen_reg;
    logic [1:0]       pending_reg;
    logic             in_xfer;
    logic             out_xfer;
    logic             set_done;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign set_done = in_xfer && (seen_reg == LAST);

    // pending_reg counts completed sets whose result has not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                seen_reg <= set_done ? '0 : seen_reg + 1'b1;
            end
            if (set_done && !out_xfer)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (!set_done && out_xfer)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_position) && $stable(y_position))
        else $error("result changed or dropped while stalled");

    a_busy_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        set_done |=> !in_ready)
        else $error("sample taken during rank scan");

    a_result_needs_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (pending_reg != '0))
        else $error("result without a completed sample set");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        set_done |=> !$rose(out_valid))
        else $error("result appeared before the scan could finish");

endmodule

bind touch_trimmed_mean_filter ttmf_checker u_ttmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x_position (x_position),
    .y_position (y_position)
);

`default_nettype wire
